// File: rtl/bptc_pkg.sv
// shared types, widths and constants for the barometric compensation block
`default_nettype none

package bptc_pkg;

    localparam int RAW_W    = 24;
    localparam int COEF_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int VALUE_W  = 18;

    localparam int DT_W     = 26;
    localparam int MUL_A_W  = 26;
    localparam int MUL_B_W  = 19;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int TEMP_W   = 22;
    localparam int OFF_W    = 36;
    localparam int SENS_W   = 35;
    localparam int ACC_W    = 60;
    localparam int DIFF_W   = 40;
    localparam int PRES_W   = 25;

    localparam logic signed [DT_W-1:0]   DT_MAX   = 26'sd16777216;
    localparam logic signed [DT_W-1:0]   DT_MIN   = -26'sd16776960;
    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 22'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 22'sd8500;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -22'sd4000;
    localparam logic signed [OFF_W-1:0]  OFF_MAX  = 36'sd12884705280;
    localparam logic signed [OFF_W-1:0]  OFF_MIN  = -36'sd8589672450;
    localparam logic signed [SENS_W-1:0] SENS_MAX = 35'sd6442352640;
    localparam logic signed [SENS_W-1:0] SENS_MIN = -35'sd4294836225;
    localparam logic signed [PRES_W-1:0] PRES_MAX = 25'sd120000;
    localparam logic signed [PRES_W-1:0] PRES_MIN = 25'sd1000;

    localparam logic signed [PROD_W-1:0] BIAS_SHR7  = 45'sd127;
    localparam logic signed [PROD_W-1:0] BIAS_SHR8  = 45'sd255;
    localparam logic signed [PROD_W-1:0] BIAS_SHR23 = 45'sd8388607;
    localparam logic signed [ACC_W-1:0]  BIAS_SHR21 = 60'sd2097151;
    localparam logic signed [DIFF_W-1:0] BIAS_SHR15 = 40'sd32767;

    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_PRES = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS         = 3'd0,
        CFG_OFFSET       = 3'd1,
        CFG_SENS_TEMPCO  = 3'd2,
        CFG_OFFSET_TEMPCO = 3'd3,
        CFG_REF_TEMP     = 3'd4,
        CFG_TEMP_SLOPE   = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_DIFF,
        ST_T_MUL,
        ST_T_DONE,
        ST_P_MUL_OFF,
        ST_P_OFF,
        ST_P_SENS,
        ST_P_MUL_LO,
        ST_P_MUL_HI,
        ST_P_ACC,
        ST_P_DIFF,
        ST_P_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_T_DIFF,
        DP_T_MUL,
        DP_T_OUT,
        DP_P_MUL_OFF,
        DP_P_OFF,
        DP_P_SENS,
        DP_P_MUL_LO,
        DP_P_MUL_HI,
        DP_P_ACC,
        DP_P_DIFF,
        DP_P_OUT
    } t_dp_op;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: rtl/bptc_sample_if.sv
// request channel carrying raw converter samples
`default_nettype none

interface bptc_sample_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [bptc_pkg::RAW_W-1:0]   raw_sample;

    modport source (output valid, output kind, output raw_sample, input ready);
    modport sink   (input valid, input kind, input raw_sample, output ready);
endinterface

`default_nettype wire

// File: rtl/bptc_result_if.sv
// handshake channel carrying compensated results
`default_nettype none

interface bptc_result_if;
    logic                                valid;
    logic                                ready;
    logic                                result_kind;
    logic signed [bptc_pkg::VALUE_W-1:0] result_value;
    logic                                out_of_range;

    modport source (output valid, output result_kind, output result_value,
                    output out_of_range, input ready);
    modport sink   (input valid, input result_kind, input result_value,
                    input out_of_range, output ready);
endinterface

`default_nettype wire

// File: rtl/bptc_datapath.sv
// datapath: coefficients, kept dT, shared multiplier and result registers
`default_nettype none

module bptc_datapath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire bptc_pkg::t_dp_cmd                    i_cmd,
    input  wire logic                                 i_kind,
    input  wire logic [bptc_pkg::RAW_W-1:0]           i_raw_sample,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [bptc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bptc_pkg::COEF_W-1:0]          i_cfg_data,
    output logic                                      o_result_kind,
    output logic signed [bptc_pkg::VALUE_W-1:0]       o_result_value,
    output logic                                      o_out_of_range
);

    logic [bptc_pkg::COEF_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic signed [bptc_pkg::DT_W-1:0] r_last_dt;

    logic                             r_kind;
    logic [bptc_pkg::RAW_W-1:0]       r_raw;
    logic signed [bptc_pkg::DT_W-1:0] r_dt_new;
    logic signed [bptc_pkg::PROD_W-1:0] r_prod;
    logic signed [bptc_pkg::OFF_W-1:0]  r_off;
    logic signed [bptc_pkg::SENS_W-1:0] r_sens;
    logic signed [bptc_pkg::ACC_W-1:0]  r_acc;
    logic signed [bptc_pkg::DIFF_W-1:0] r_diff;

    logic                                r_res_kind;
    logic signed [bptc_pkg::VALUE_W-1:0] r_res_value;
    logic                                r_res_bad;

    logic signed [bptc_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [bptc_pkg::MUL_B_W-1:0] w_mul_b;
    logic                                w_mul_en;
    logic signed [bptc_pkg::PROD_W-1:0]  w_prod;

    logic signed [bptc_pkg::DT_W-1:0]    w_dt;
    logic signed [bptc_pkg::PROD_W-1:0]  w_prod_b7, w_prod_b8, w_prod_b23;
    logic signed [bptc_pkg::TEMP_W-1:0]  w_temp;
    logic                                w_temp_bad;
    logic signed [bptc_pkg::OFF_W-1:0]   w_off;
    logic signed [bptc_pkg::SENS_W-1:0]  w_sens;
    logic signed [bptc_pkg::ACC_W-1:0]   w_acc_b;
    logic signed [bptc_pkg::DIFF_W-1:0]  w_q;
    logic signed [bptc_pkg::DIFF_W-1:0]  w_diff_b;
    logic signed [bptc_pkg::PRES_W-1:0]  w_pres;
    logic                                w_pres_bad;

    // configuration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bptc_pkg::CFG_SENS:          r_c1 <= i_cfg_data;
                bptc_pkg::CFG_OFFSET:        r_c2 <= i_cfg_data;
                bptc_pkg::CFG_SENS_TEMPCO:   r_c3 <= i_cfg_data;
                bptc_pkg::CFG_OFFSET_TEMPCO: r_c4 <= i_cfg_data;
                bptc_pkg::CFG_REF_TEMP:      r_c5 <= i_cfg_data;
                bptc_pkg::CFG_TEMP_SLOPE:    r_c6 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // shared multiplier operand selection
    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b0;
        case (i_cmd.op)
            bptc_pkg::DP_T_MUL: begin
                w_mul_a  = r_dt_new;
                w_mul_b  = $signed({3'b000, r_c6});
                w_mul_en = 1'b1;
            end
            bptc_pkg::DP_P_MUL_OFF: begin
                w_mul_a  = r_last_dt;
                w_mul_b  = $signed({3'b000, r_c4});
                w_mul_en = 1'b1;
            end
            bptc_pkg::DP_P_OFF: begin
                w_mul_a  = r_last_dt;
                w_mul_b  = $signed({3'b000, r_c3});
                w_mul_en = 1'b1;
            end
            bptc_pkg::DP_P_MUL_LO: begin
                w_mul_a  = $signed({2'b00, r_raw});
                w_mul_b  = $signed({3'b000, r_sens[15:0]});
                w_mul_en = 1'b1;
            end
            bptc_pkg::DP_P_MUL_HI: begin
                w_mul_a  = $signed({2'b00, r_raw});
                w_mul_b  = r_sens[bptc_pkg::SENS_W-1:16];
                w_mul_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // truncating shifts: add (2^k - 1) to negative values first
    assign w_dt = $signed({2'b00, r_raw}) - $signed({2'b00, r_c5, 8'h00});

    assign w_prod_b23 = r_prod + (r_prod[bptc_pkg::PROD_W-1] ? bptc_pkg::BIAS_SHR23 : '0);
    assign w_temp = $signed(w_prod_b23[44:23]) + bptc_pkg::TEMP_BASE;
    assign w_temp_bad = (r_dt_new > bptc_pkg::DT_MAX) || (r_dt_new < bptc_pkg::DT_MIN) ||
                        (w_temp > bptc_pkg::TEMP_MAX) || (w_temp < bptc_pkg::TEMP_MIN);

    assign w_prod_b7 = r_prod + (r_prod[bptc_pkg::PROD_W-1] ? bptc_pkg::BIAS_SHR7 : '0);
    assign w_off = $signed({4'h0, r_c2, 16'h0000}) + $signed(w_prod_b7[42:7]);

    assign w_prod_b8 = r_prod + (r_prod[bptc_pkg::PROD_W-1] ? bptc_pkg::BIAS_SHR8 : '0);
    assign w_sens = $signed({4'h0, r_c1, 15'h0000}) + $signed(w_prod_b8[42:8]);

    assign w_acc_b = r_acc + (r_acc[bptc_pkg::ACC_W-1] ? bptc_pkg::BIAS_SHR21 : '0);
    assign w_q = bptc_pkg::DIFF_W'($signed(w_acc_b[59:21]));

    assign w_diff_b = r_diff + (r_diff[bptc_pkg::DIFF_W-1] ? bptc_pkg::BIAS_SHR15 : '0);
    assign w_pres = $signed(w_diff_b[39:15]);
    assign w_pres_bad = (r_off > bptc_pkg::OFF_MAX) || (r_off < bptc_pkg::OFF_MIN) ||
                        (r_sens > bptc_pkg::SENS_MAX) || (r_sens < bptc_pkg::SENS_MIN) ||
                        (w_pres > bptc_pkg::PRES_MAX) || (w_pres < bptc_pkg::PRES_MIN);

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_raw  <= i_raw_sample;
        end
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        case (i_cmd.op)
            bptc_pkg::DP_T_DIFF:   r_dt_new <= w_dt;
            bptc_pkg::DP_P_OFF:    r_off    <= w_off;
            bptc_pkg::DP_P_SENS:   r_sens   <= w_sens;
            bptc_pkg::DP_P_MUL_HI: r_acc    <= bptc_pkg::ACC_W'(r_prod);
            bptc_pkg::DP_P_ACC:    r_acc    <= r_acc + $signed({r_prod[43:0], 16'h0000});
            bptc_pkg::DP_P_DIFF:   r_diff   <= w_q - bptc_pkg::DIFF_W'(r_off);
            default: begin
            end
        endcase
    end

    // kept temperature difference
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_dt <= '0;
        end else if ((i_cmd.op == bptc_pkg::DP_T_OUT) && !w_temp_bad) begin
            r_last_dt <= r_dt_new;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bptc_pkg::DP_T_OUT: begin
                r_res_kind  <= r_kind;
                r_res_value <= w_temp_bad ? '0 : w_temp[bptc_pkg::VALUE_W-1:0];
                r_res_bad   <= w_temp_bad;
            end
            bptc_pkg::DP_P_OUT: begin
                r_res_kind  <= r_kind;
                r_res_value <= w_pres_bad ? '0 : w_pres[bptc_pkg::VALUE_W-1:0];
                r_res_bad   <= w_pres_bad;
            end
            default: begin
            end
        endcase
    end

    assign o_result_kind  = r_res_kind;
    assign o_result_value = r_res_value;
    assign o_out_of_range = r_res_bad;

endmodule

`default_nettype wire

// File: rtl/bptc_ctrl.sv
// controller: sequences the datapath and holds the result valid flag
`default_nettype none

module bptc_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_kind,
    input  wire logic         i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output bptc_pkg::t_dp_cmd o_cmd
);

    bptc_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bptc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bptc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_kind == bptc_pkg::KIND_PRES) ?
                              bptc_pkg::ST_P_MUL_OFF : bptc_pkg::ST_T_DIFF;
                end
            end
            bptc_pkg::ST_T_DIFF:    n_state = bptc_pkg::ST_T_MUL;
            bptc_pkg::ST_T_MUL:     n_state = bptc_pkg::ST_T_DONE;
            bptc_pkg::ST_T_DONE: begin
                if (w_out_free) begin
                    n_state = bptc_pkg::ST_IDLE;
                end
            end
            bptc_pkg::ST_P_MUL_OFF: n_state = bptc_pkg::ST_P_OFF;
            bptc_pkg::ST_P_OFF:     n_state = bptc_pkg::ST_P_SENS;
            bptc_pkg::ST_P_SENS:    n_state = bptc_pkg::ST_P_MUL_LO;
            bptc_pkg::ST_P_MUL_LO:  n_state = bptc_pkg::ST_P_MUL_HI;
            bptc_pkg::ST_P_MUL_HI:  n_state = bptc_pkg::ST_P_ACC;
            bptc_pkg::ST_P_ACC:     n_state = bptc_pkg::ST_P_DIFF;
            bptc_pkg::ST_P_DIFF:    n_state = bptc_pkg::ST_P_DONE;
            bptc_pkg::ST_P_DONE: begin
                if (w_out_free) begin
                    n_state = bptc_pkg::ST_IDLE;
                end
            end
            default:                n_state = bptc_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.op    = bptc_pkg::DP_NOP;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            bptc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            bptc_pkg::ST_T_DIFF:    o_cmd.op = bptc_pkg::DP_T_DIFF;
            bptc_pkg::ST_T_MUL:     o_cmd.op = bptc_pkg::DP_T_MUL;
            bptc_pkg::ST_T_DONE: begin
                // result register must be empty or draining this cycle
                if (w_out_free) begin
                    o_cmd.op    = bptc_pkg::DP_T_OUT;
                    n_out_valid = 1'b1;
                end
            end
            bptc_pkg::ST_P_MUL_OFF: o_cmd.op = bptc_pkg::DP_P_MUL_OFF;
            bptc_pkg::ST_P_OFF:     o_cmd.op = bptc_pkg::DP_P_OFF;
            bptc_pkg::ST_P_SENS:    o_cmd.op = bptc_pkg::DP_P_SENS;
            bptc_pkg::ST_P_MUL_LO:  o_cmd.op = bptc_pkg::DP_P_MUL_LO;
            bptc_pkg::ST_P_MUL_HI:  o_cmd.op = bptc_pkg::DP_P_MUL_HI;
            bptc_pkg::ST_P_ACC:     o_cmd.op = bptc_pkg::DP_P_ACC;
            bptc_pkg::ST_P_DIFF:    o_cmd.op = bptc_pkg::DP_P_DIFF;
            bptc_pkg::ST_P_DONE: begin
                if (w_out_free) begin
                    o_cmd.op    = bptc_pkg::DP_P_OUT;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/baro_temp_pressure_compensation.sv
// top level: first-order barometric temperature and pressure compensation
// Usage:
//   i_sample carries one raw 24-bit reading per request, tagged by kind as a
//   temperature (0) or pressure (1) sample. o_result returns exactly one
//   result per request: its kind, the value (0.01 degC or Pa, 0 on error)
//   and an out-of-range flag. The six calibration words are written through
//   i_cfg_wr_en / i_cfg_index / i_cfg_data while the block is idle.
// Timing:
//   one request at a time passes through a single shared 26x19 multiplier
//   stepped by the controller. A temperature request takes the accept plus
//   3 steps, a pressure request the accept plus 8 steps; the final step
//   waits while the output register holds an untaken result, and the result
//   appears on o_result in the cycle after the last step.
// Reset and stalls:
//   synchronous reset clears the calibration words, the kept temperature
//   difference and the result valid flag. A finished result is held in an
//   output register, so a new request is accepted while it waits; if the
//   receiver stalls, the next item's final step waits until the register
//   drains, and no further request is taken meanwhile.
`default_nettype none

module baro_temp_pressure_compensation (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    bptc_sample_if.sink                             i_sample,
    bptc_result_if.source                           o_result,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [bptc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bptc_pkg::COEF_W-1:0]        i_cfg_data
);

    bptc_pkg::t_dp_cmd w_cmd;

    bptc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .i_in_kind   (i_sample.kind),
        .i_out_ready (o_result.ready),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (w_cmd)
    );

    bptc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_kind         (i_sample.kind),
        .i_raw_sample   (i_sample.raw_sample),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_kind  (o_result.result_kind),
        .o_result_value (o_result.result_value),
        .o_out_of_range (o_result.out_of_range)
    );

endmodule

`default_nettype wire
